/* design/assert_macros.svh */
// Assertion macros used by the checker file of the timer bank.
// Every check is clocked on the rising edge and is held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion with the active-low reset as the disable.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge.
`define CHK_NEVER(label, clk, rst_n, expr, msg) \
    `CHK_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

/* design/stb_pkg.sv */
// Shared types and constants for the software timer bank.
// Used by the controller, the datapath, the top level and the checker.
package stb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int MAX_OUT    = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int SLOT_W     = 3;
    localparam int TICK_W     = 32;

    // Request opcodes
    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_POLL  = 3'd3,
        CMD_QUERY = 3'd4
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NO_SLOT   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Per-slot timer state
    typedef enum logic [1:0] {
        SS_INACTIVE = 2'd0,
        SS_ACTIVE   = 2'd1,
        SS_PENDING  = 2'd2
    } t_slot_st;

    // Datapath operations issued by the controller
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_EXEC = 2'd1,
        OP_TICK = 2'd2,
        OP_POLL = 2'd3
    } t_dp_op;

    // Datapath status seen by the controller
    typedef struct packed {
        logic idx_end;
        logic cur_pending;
        logic none_pending;
        logic out_last;
    } t_dp_stat;

endpackage

/* design/stb_ctrl.sv */
// Controller state machine for the timer bank.
// Depends on stb_pkg; drives datapath operations and the channel handshakes.
module stb_ctrl import stb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_cmd,
    input  logic       i_stall,
    input  t_dp_stat   i_stat,
    output t_dp_op     o_op,
    output logic       o_stall,
    output logic       o_valid
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TICK = 4'b0010,
        S_POLL = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Next state and datapath operation
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op = OP_EXEC;
                    case (t_cmd'(i_cmd))
                        CMD_TICK: n_state = S_TICK;
                        CMD_POLL: n_state = i_stat.none_pending ? S_EMIT : S_POLL;
                        default:  n_state = S_EMIT;
                    endcase
                end
            end
            S_TICK: begin
                o_op = OP_TICK;
                if (i_stat.idx_end) begin
                    n_state = S_EMIT;
                end
            end
            S_POLL: begin
                o_op = OP_POLL;
                if (i_stat.cur_pending) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_stall) begin
                    n_state = i_stat.out_last ? S_IDLE : S_POLL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);

endmodule

/* design/stb_dp.sv */
// Datapath of the timer bank: tick counter, slot tables, walk index and result register.
// Depends on stb_pkg; operated by stb_ctrl through t_dp_op.
module stb_dp import stb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_op              i_op,
    input  logic [2:0]          i_cmd,
    input  logic [TICK_W-1:0]   i_interval,
    input  logic                i_repeat_mode,
    input  logic [SLOT_W-1:0]   i_slot,
    output t_dp_stat            o_stat,
    output logic [1:0]          o_status,
    output logic [SLOT_W-1:0]   o_slot_id,
    output logic [1:0]          o_slot_status,
    output logic                o_expired,
    output logic [TICK_W-1:0]   o_tick_now,
    output logic                o_last
);

    // Control state (reset)
    logic [TICK_W-1:0] r_tick;
    t_slot_st          r_sstate [NUM_TIMERS];
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;

    // Slot tables, valid only once a start has written the slot
    logic              r_rep   [NUM_TIMERS];
    logic [TICK_W-1:0] r_start [NUM_TIMERS];
    logic [TICK_W-1:0] r_ival  [NUM_TIMERS];

    // Result register
    t_status           r_status;
    logic [SLOT_W-1:0] r_slot_id;
    t_slot_st          r_slot_st;
    logic              r_expired;
    logic              r_last;

    logic [NUM_TIMERS-1:0] pend_mask;
    logic [NUM_TIMERS-1:0] pend_above;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      req_idx;
    logic                  req_in_range;
    logic [TICK_W-1:0]     elapsed;
    logic                  fire;
    logic                  poll_last;
    logic                  idx_end;

    // Pending map, pending slots above the walk index, lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            pend_mask[i]  = (r_sstate[i] == SS_PENDING);
            pend_above[i] = pend_mask[i] && (IDX_W'(i) > r_idx);
        end
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (r_sstate[i] == SS_INACTIVE) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign req_idx      = IDX_W'(i_slot);
    assign req_in_range = ({1'b0, i_slot} < (SLOT_W + 1)'(NUM_TIMERS));
    assign idx_end      = (r_idx == IDX_W'(NUM_TIMERS - 1));

    // Expiry test for the slot under the walk index
    assign elapsed   = r_tick - r_start[r_idx];
    assign fire      = (r_sstate[r_idx] == SS_ACTIVE) && (elapsed >= r_ival[r_idx]);
    assign poll_last = !(|pend_above) || (r_cnt == CNT_W'(MAX_OUT - 1));

    // Tick count, slot states, walk index and result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_idx  <= '0;
            r_cnt  <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_sstate[i] <= SS_INACTIVE;
            end
        end else begin
            unique case (i_op)
                OP_EXEC: begin
                    r_idx <= '0;
                    r_cnt <= '0;
                    case (t_cmd'(i_cmd))
                        CMD_TICK: r_tick <= r_tick + TICK_W'(1);
                        CMD_START: begin
                            if (i_interval != '0 && free_found) begin
                                r_sstate[free_idx] <= SS_ACTIVE;
                            end
                        end
                        CMD_STOP: begin
                            if (req_in_range && r_sstate[req_idx] != SS_INACTIVE) begin
                                r_sstate[req_idx] <= SS_INACTIVE;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_TICK: begin
                    if (fire) begin
                        r_sstate[r_idx] <= SS_PENDING;
                    end
                    r_idx <= idx_end ? '0 : r_idx + IDX_W'(1);
                end
                OP_POLL: begin
                    if (pend_mask[r_idx]) begin
                        r_sstate[r_idx] <= r_rep[r_idx] ? SS_ACTIVE : SS_INACTIVE;
                        r_cnt           <= r_cnt + CNT_W'(1);
                    end
                    r_idx <= idx_end ? '0 : r_idx + IDX_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Slot tables: written by start, start time moved on by a repeating expiry
    always_ff @(posedge i_clk) begin
        if (i_op == OP_EXEC && t_cmd'(i_cmd) == CMD_START && i_interval != '0
            && free_found) begin
            r_rep[free_idx]   <= i_repeat_mode;
            r_start[free_idx] <= r_tick;
            r_ival[free_idx]  <= i_interval;
        end else if (i_op == OP_TICK && fire && r_rep[r_idx]) begin
            r_start[r_idx] <= r_start[r_idx] + r_ival[r_idx];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_EXEC: begin
                r_status  <= ST_OK;
                r_slot_id <= '0;
                r_slot_st <= SS_INACTIVE;
                r_expired <= 1'b0;
                r_last    <= 1'b1;
                case (t_cmd'(i_cmd))
                    CMD_TICK, CMD_POLL: ;
                    CMD_START: begin
                        if (i_interval == '0) begin
                            r_status <= ST_INVALID;
                        end else if (!free_found) begin
                            r_status <= ST_NO_SLOT;
                        end else begin
                            r_slot_id <= SLOT_W'(free_idx);
                        end
                    end
                    CMD_STOP: begin
                        r_slot_id <= i_slot;
                        if (!(req_in_range && r_sstate[req_idx] != SS_INACTIVE)) begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end
                    CMD_QUERY: begin
                        r_slot_id <= i_slot;
                        if (req_in_range) begin
                            r_slot_st <= r_sstate[req_idx];
                        end else begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end
                    default: r_status <= ST_INVALID;
                endcase
            end
            OP_TICK: begin
                if (idx_end) begin
                    r_status  <= ST_OK;
                    r_slot_id <= '0;
                    r_slot_st <= SS_INACTIVE;
                    r_expired <= 1'b0;
                    r_last    <= 1'b1;
                end
            end
            OP_POLL: begin
                if (pend_mask[r_idx]) begin
                    r_status  <= ST_OK;
                    r_slot_id <= SLOT_W'(r_idx);
                    r_slot_st <= SS_INACTIVE;
                    r_expired <= 1'b1;
                    r_last    <= poll_last;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.idx_end      = idx_end;
    assign o_stat.cur_pending  = pend_mask[r_idx];
    assign o_stat.none_pending = ~|pend_mask;
    assign o_stat.out_last     = r_last;

    assign o_status      = r_status;
    assign o_slot_id     = r_slot_id;
    assign o_slot_status = r_slot_st;
    assign o_expired     = r_expired;
    assign o_tick_now    = r_tick;
    assign o_last        = r_last;

endmodule

/* design/soft_timer_bank_core.sv */
// Bank of software timers: tick, start, stop, poll and query requests.
// Instantiates stb_ctrl and stb_dp; depends on stb_pkg.
//
// Usage:
// - Request channel i_valid/o_stall carries i_cmd, i_interval, i_repeat_mode
//   and i_slot; a request is taken on an edge with i_valid high, o_stall low.
// - Result channel o_valid/i_stall carries o_status, o_slot_id, o_slot_status,
//   o_expired, o_tick_now and o_last; o_last marks a request's final result.
// - One request is in flight at a time; o_stall is high from acceptance until
//   the last result of that request has been taken.
// - Start, stop, query and unknown codes: result valid in the cycle after accept.
// - Tick: the walk visits one slot per cycle, and the result is valid once
//   the walk has passed the last slot.
// - Poll: the same one-slot-per-cycle walk, paused while each result is out;
//   each pending slot gives a result as the walk reaches it.
// - The walk over the slot tables, one slot per cycle, paces tick and poll.
// - A stalled result holds its value and the walk pauses until it is taken.
// - Sync reset clears the tick count and marks all slots inactive; no
//   clearing pass is needed, requests are taken from the first cycle.
module soft_timer_bank_core import stb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_cmd,
    input  logic [TICK_W-1:0]   i_interval,
    input  logic                i_repeat_mode,
    input  logic [SLOT_W-1:0]   i_slot,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [SLOT_W-1:0]   o_slot_id,
    output logic [1:0]          o_slot_status,
    output logic                o_expired,
    output logic [TICK_W-1:0]   o_tick_now,
    output logic                o_last
);

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    // Sequencer
    stb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_op    (dp_op),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    // Counter, slot tables and result register
    stb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (dp_op),
        .i_cmd         (i_cmd),
        .i_interval    (i_interval),
        .i_repeat_mode (i_repeat_mode),
        .i_slot        (i_slot),
        .o_stat        (dp_stat),
        .o_status      (o_status),
        .o_slot_id     (o_slot_id),
        .o_slot_status (o_slot_status),
        .o_expired     (o_expired),
        .o_tick_now    (o_tick_now),
        .o_last        (o_last)
    );

endmodule

/* design/soft_timer_bank_chk.sv */
// Port-level checker for soft_timer_bank_core, bound to the top level.
// Depends on stb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module soft_timer_bank_chk import stb_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic [2:0]          i_cmd,
    input logic                o_valid,
    input logic                i_stall,
    input logic [1:0]          o_status,
    input logic [SLOT_W-1:0]   o_slot_id,
    input logic [1:0]          o_slot_status,
    input logic                o_expired,
    input logic [TICK_W-1:0]   o_tick_now,
    input logic                o_last
);

    logic req_take;
    logic tick_take;
    logic bad_exp;

    // Accepted request and accepted tick
    assign req_take  = i_valid && !o_stall;
    assign tick_take = req_take && (i_cmd == CMD_TICK);
    assign bad_exp   = o_valid && o_expired
                       && (o_status != ST_OK || o_slot_status != SS_INACTIVE);

    // A stalled result keeps its identity
    property p_out_hold;
        o_valid && i_stall |=> o_valid && $stable(o_slot_id) && $stable(o_last)
            && $stable(o_status);
    endproperty

    // An accepted tick advances the count by one
    property p_tick_inc;
        tick_take |=> o_tick_now == $past(o_tick_now) + TICK_W'(1);
    endproperty

    // Without a tick request the count holds
    property p_tick_hold;
        !tick_take |=> $stable(o_tick_now);
    endproperty

    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "result changed while stalled")

    // No new request is taken while a result is outstanding
    `CHK_NEVER(a_one_req, i_clk, i_rst_n, o_valid && !o_stall, "request taken while busy")

    `CHK_ASSERT(a_tick_inc, i_clk, i_rst_n, p_tick_inc, "tick count did not advance")

    `CHK_ASSERT(a_tick_hold, i_clk, i_rst_n, p_tick_hold, "tick count moved without a tick")

    // Expiry reports carry an ok status and no slot state
    `CHK_NEVER(a_exp_ok, i_clk, i_rst_n, bad_exp, "malformed expiry report")

endmodule

bind soft_timer_bank_core soft_timer_bank_chk u_chk (.*);
